@@ hw/rtl/pcc_pkg.sv @@
// Shared types and constants for the prefix code table codec.
package pcc_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int TABLE_SIZE   = 257;
    localparam int END_INDEX    = 256;
    localparam int LEN_W        = 6;
    localparam int ADDR_W       = 9;
    localparam int ENTRY_W      = LEN_W + MAX_CODE_LEN;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_ENCODE  = 3'd1;
    localparam logic [2:0] OP_FINISH  = 3'd2;
    localparam logic [2:0] OP_DECODE  = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_SYMBOL = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [8:0]  symbol;
        logic [5:0]  code_length;
        logic [31:0] code_bits;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } out_item_t;

    // Result command from the core to the output queue
    typedef struct packed {
        logic       push;
        logic       fin;
        logic [1:0] kind;
        logic [7:0] value;
    } res_cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ENC_WAIT,
        S_ENC_BIT,
        S_FLUSH,
        S_ERR,
        S_DEC_BIT,
        S_DEC_SCAN,
        S_DEC_HIT,
        S_DEC_OVR,
        S_FIN
    } state_t;

endpackage

@@ hw/rtl/pcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/pcc_outq.sv @@
// Result output stage: one held result (to mark last) plus the output register.
module pcc_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  pcc_pkg::res_cmd_t cmd,
    output logic              rdy,
    output logic              out_valid,
    input  logic              out_stall,
    output pcc_pkg::out_item_t out_data
);
    import pcc_pkg::*;

    logic       pend_v_reg, pend_v_next;
    logic [1:0] pend_kind_reg, pend_kind_next;
    logic [7:0] pend_val_reg, pend_val_next;
    logic       out_v_reg, out_v_next;
    out_item_t  out_reg, out_next;

    assign rdy       = !out_v_reg || !out_stall;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // Held result goes out when the next one arrives or the transaction ends
    always_comb
    begin
        pend_v_next    = pend_v_reg;
        pend_kind_next = pend_kind_reg;
        pend_val_next  = pend_val_reg;
        out_next       = out_reg;
        out_v_next     = out_v_reg && out_stall;
        if (cmd.push && rdy)
        begin
            if (pend_v_reg)
            begin
                out_v_next = 1'b1;
                out_next   = '{kind: pend_kind_reg, value: pend_val_reg, last: 1'b0};
            end
            pend_v_next    = 1'b1;
            pend_kind_next = cmd.kind;
            pend_val_next  = cmd.value;
        end
        else if (cmd.fin && rdy)
        begin
            if (pend_v_reg)
            begin
                out_v_next = 1'b1;
                out_next   = '{kind: pend_kind_reg, value: pend_val_reg, last: 1'b1};
            end
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_val_reg  <= pend_val_next;
        out_reg       <= out_next;
    end

    // Held result never lingers once a transaction ended
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && rdy && !cmd.push) |=> !pend_v_reg)
        else $error("held result survived end of transaction");
    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && rdy) |=> pend_v_reg)
        else $error("pushed result not held");
    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy && (cmd.push || cmd.fin) && pend_v_reg) |=> out_v_reg)
        else $error("held result lost");

endmodule

@@ hw/rtl/pcc_core.sv @@
// Sequencer: table load, encode bit packer and table-scan decoder.
module pcc_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  pcc_pkg::in_item_t          in_data,
    output logic                       ram_wr_en,
    output logic [pcc_pkg::ADDR_W-1:0] ram_wr_addr,
    output logic [pcc_pkg::ENTRY_W-1:0] ram_wr_data,
    output logic [pcc_pkg::ADDR_W-1:0] ram_rd_addr,
    input  logic [pcc_pkg::ENTRY_W-1:0] ram_rd_data,
    output pcc_pkg::res_cmd_t          cmd,
    input  logic                       rdy
);
    import pcc_pkg::*;

    state_t                  state_reg, state_next;
    in_item_t                item_reg, item_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic [MAX_CODE_LEN-1:0] code_reg, code_next;
    logic [7:0]              pack_byte_reg, pack_byte_next;
    logic [2:0]              pack_count_reg, pack_count_next;
    logic [MAX_CODE_LEN-1:0] prefix_reg, prefix_next;
    logic [LEN_W-1:0]        plen_reg, plen_next;
    logic                    stopped_reg, stopped_next;
    logic [2:0]              j_reg, j_next;

    logic [LEN_W-1:0]        rd_len;
    logic [MAX_CODE_LEN-1:0] rd_bits;
    logic [MAX_CODE_LEN-1:0] load_mask;
    logic                    match;
    logic [LEN_W-1:0]        cidx;
    logic                    enc_bit;
    logic [7:0]              enc_byte;
    logic                    accept;

    assign rd_len  = ram_rd_data[ENTRY_W-1 -: LEN_W];
    assign rd_bits = ram_rd_data[MAX_CODE_LEN-1:0];
    assign match   = (rd_len != '0) && (rd_len == plen_reg) && (rd_bits == prefix_reg);
    assign cidx    = cnt_reg - LEN_W'(1);
    assign enc_bit = code_reg[cidx[$clog2(MAX_CODE_LEN)-1:0]];
    assign enc_byte = pack_byte_reg | (8'({7'd0, enc_bit}) << (3'd7 - pack_count_reg));
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Keep only code bits below the loaded length
    always_comb
    begin
        for (int i = 0; i < MAX_CODE_LEN; i++)
        begin
            load_mask[i] = (LEN_W'(i) < item_reg.code_length);
        end
    end

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        code_next       = code_reg;
        pack_byte_next  = pack_byte_reg;
        pack_count_next = pack_count_reg;
        prefix_next     = prefix_reg;
        plen_next       = plen_reg;
        stopped_next    = stopped_reg;
        j_next          = j_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = '0;
        ram_rd_addr     = idx_reg;
        cmd             = '{push: 1'b0, fin: 1'b0, kind: KIND_BYTE, value: 8'd0};

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(END_INDEX))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_rd_addr = (in_data.operation == OP_FINISH) ? ADDR_W'(END_INDEX)
                                                               : ADDR_W'(in_data.data_byte);
                if (accept)
                begin
                    item_next = in_data;
                    case (in_data.operation)
                        OP_LOAD:    state_next = S_LOAD;
                        OP_ENCODE:  state_next = S_ENC_WAIT;
                        OP_FINISH:  state_next = S_ENC_WAIT;
                        OP_DECODE:
                        begin
                            j_next     = 3'd0;
                            state_next = stopped_reg ? S_FIN : S_DEC_BIT;
                        end
                        OP_RESTART:
                        begin
                            prefix_next  = '0;
                            plen_next    = '0;
                            stopped_next = 1'b0;
                            state_next   = S_FIN;
                        end
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (item_reg.symbol > ADDR_W'(END_INDEX)
                    || item_reg.code_length > LEN_W'(MAX_CODE_LEN))
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = item_reg.symbol;
                    ram_wr_data = {item_reg.code_length,
                                   MAX_CODE_LEN'(item_reg.code_bits) & load_mask};
                    state_next  = S_FIN;
                end
            end
            S_ENC_WAIT:
            begin
                cnt_next  = rd_len;
                code_next = rd_bits;
                state_next = (rd_len == '0) ? S_ERR : S_ENC_BIT;
            end
            S_ENC_BIT:
            begin
                if (!(pack_count_reg == 3'd7) || rdy)
                begin
                    if (pack_count_reg == 3'd7)
                    begin
                        cmd = '{push: 1'b1, fin: 1'b0, kind: KIND_BYTE, value: enc_byte};
                        pack_byte_next = 8'd0;
                    end
                    else
                    begin
                        pack_byte_next = enc_byte;
                    end
                    pack_count_next = pack_count_reg + 3'd1;
                    cnt_next        = cidx;
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = (item_reg.operation == OP_FINISH) ? S_FLUSH : S_FIN;
                    end
                end
            end
            S_FLUSH:
            begin
                if (pack_count_reg == 3'd0)
                begin
                    state_next = S_FIN;
                end
                else if (rdy)
                begin
                    cmd = '{push: 1'b1, fin: 1'b0, kind: KIND_BYTE, value: pack_byte_reg};
                    pack_byte_next  = 8'd0;
                    pack_count_next = 3'd0;
                    state_next      = S_FIN;
                end
            end
            S_ERR:
            begin
                if (rdy)
                begin
                    cmd = '{push: 1'b1, fin: 1'b0, kind: KIND_ERROR, value: 8'd0};
                    state_next = S_FIN;
                end
            end
            S_DEC_BIT:
            begin
                prefix_next = {prefix_reg[MAX_CODE_LEN-2:0], item_reg.data_byte[3'd7 - j_reg]};
                plen_next   = plen_reg + LEN_W'(1);
                idx_next    = '0;
                ram_rd_addr = '0;
                state_next  = S_DEC_SCAN;
            end
            S_DEC_SCAN:
            begin
                // read data belongs to entry idx_reg; fetch the following one
                ram_rd_addr = idx_reg + ADDR_W'(1);
                if (match)
                begin
                    state_next = S_DEC_HIT;
                end
                else if (idx_reg == ADDR_W'(END_INDEX))
                begin
                    if (plen_reg >= LEN_W'(MAX_CODE_LEN))
                    begin
                        state_next = S_DEC_OVR;
                    end
                    else
                    begin
                        j_next     = j_reg + 3'd1;
                        state_next = (j_reg == 3'd7) ? S_FIN : S_DEC_BIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_DEC_HIT:
            begin
                if (rdy)
                begin
                    prefix_next = '0;
                    plen_next   = '0;
                    if (idx_reg == ADDR_W'(END_INDEX))
                    begin
                        cmd = '{push: 1'b1, fin: 1'b0, kind: KIND_END, value: 8'd0};
                        stopped_next = 1'b1;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        cmd = '{push: 1'b1, fin: 1'b0, kind: KIND_SYMBOL,
                                value: idx_reg[7:0]};
                        j_next     = j_reg + 3'd1;
                        state_next = (j_reg == 3'd7) ? S_FIN : S_DEC_BIT;
                    end
                end
            end
            S_DEC_OVR:
            begin
                if (rdy)
                begin
                    cmd = '{push: 1'b1, fin: 1'b0, kind: KIND_ERROR, value: 8'd0};
                    prefix_next = '0;
                    plen_next   = '0;
                    j_next      = j_reg + 3'd1;
                    state_next  = (j_reg == 3'd7) ? S_FIN : S_DEC_BIT;
                end
            end
            S_FIN:
            begin
                if (rdy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            pack_byte_reg  <= '0;
            pack_count_reg <= '0;
            prefix_reg     <= '0;
            plen_reg       <= '0;
            stopped_reg    <= 1'b0;
            j_reg          <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pack_byte_reg  <= pack_byte_next;
            pack_count_reg <= pack_count_next;
            prefix_reg     <= prefix_next;
            plen_reg       <= plen_next;
            stopped_reg    <= stopped_next;
            j_reg          <= j_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        code_reg <= code_next;
    end

    a_push_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.fin))
        else $error("push and end of transaction together");
    a_cmd_when_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.fin) |-> rdy)
        else $error("result issued while output busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction not started");
    a_stop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stopped_reg) |-> $past(state_reg) == S_DEC_HIT)
        else $error("decoder stopped without end code");

endmodule

@@ hw/rtl/prefix_code_table_codec.sv @@
// Top level of the prefix code table codec.
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one transaction per
//   operation: load table entry, encode byte, finish encode, decode byte,
//   restart decoder. Output channel (out_valid / out_stall / out_data) gives
//   encoded bytes, decoded symbols, end markers and errors; last marks the
//   final result of an input transaction.
//   The code table lives in a 257 x 38 RAM with one read port. Load writes
//   one entry; encode reads the entry and packs its code one bit at a time,
//   and finish also flushes a partial byte. Decode scans the table through
//   that read port once per coded bit, stopping at the first matching entry.
//   One transaction is worked on at a time; in_stall is high while busy.
//   Results pass one held stage and an output register, so a stalled
//   receiver holds the core whenever it issues a result while the output
//   register is full.
//   After reset the table is cleared by a pass over all 257 entries; in_stall
//   stays high until it finishes.
module prefix_code_table_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pcc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pcc_pkg::out_item_t out_data
);
    import pcc_pkg::*;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;
    res_cmd_t            cmd;
    logic                rdy;

    pcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pcc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .cmd         (cmd),
        .rdy         (rdy)
    );

    pcc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rdy       (rdy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
